// ===== hdl/rle_pkg.sv =====
`timescale 1ns / 1ps

package rle_pkg;

    // Cluster geometry and field widths.
    localparam int C_NODES      = 16;
    localparam int C_ID_W       = $clog2(C_NODES);
    localparam int C_SIZE_W     = $clog2(C_NODES + 1);
    localparam int C_TERM_W     = 32;
    localparam int C_WAIT_W     = 9;
    localparam int C_LIMIT_W    = 9;
    localparam int C_REMAIN_W   = 10;
    localparam int C_PERIOD_W   = 8;
    localparam int C_LFSR_W     = 16;
    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 16;

    localparam logic [C_LFSR_W-1:0] C_LFSR_TAPS = 16'hB400;

    // Reset values of the configuration registers.
    localparam logic [C_ID_W-1:0]     C_RST_OWN_ID   = 4'd0;
    localparam logic [C_SIZE_W-1:0]   C_RST_CLUSTER  = 5'd3;
    localparam logic [C_PERIOD_W-1:0] C_RST_HB_PER   = 8'd5;
    localparam logic [C_PERIOD_W-1:0] C_RST_RV_PER   = 8'd5;
    localparam logic [C_PERIOD_W-1:0] C_RST_BASE     = 8'd10;
    localparam logic [C_LFSR_W-1:0]   C_RST_SEED     = 16'd44257;

    // Configuration register indexes.
    localparam logic [C_CFG_IDX_W-1:0] CFG_OWN_ID       = 3'd0;
    localparam logic [C_CFG_IDX_W-1:0] CFG_CLUSTER_SIZE = 3'd1;
    localparam logic [C_CFG_IDX_W-1:0] CFG_HB_PERIOD    = 3'd2;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RV_PERIOD    = 3'd3;
    localparam logic [C_CFG_IDX_W-1:0] CFG_ELECT_BASE   = 3'd4;
    localparam logic [C_CFG_IDX_W-1:0] CFG_RANDOM_SEED  = 3'd5;

    // Received operations.
    localparam logic [2:0] OP_HEARTBEAT = 3'd0;
    localparam logic [2:0] OP_VOTE_REQ  = 3'd1;
    localparam logic [2:0] OP_VOTE      = 3'd2;
    localparam logic [2:0] OP_ACK       = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // Sent message kinds.
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_VOTE = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;
    localparam logic [1:0] KIND_HB   = 2'd3;

    // Node roles.
    localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [1:0] ROLE_LEADER    = 2'd2;

    typedef struct packed {
        logic [2:0]          operation;
        logic [C_ID_W-1:0]   sender_id;
        logic [C_TERM_W-1:0] msg_term;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          send_kind;
        logic [C_ID_W-1:0]   dest_id;
        logic [C_TERM_W-1:0] send_term;
        logic [1:0]          node_role;
        logic                last_of_run;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic pop;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pending;
        logic last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/raft_leader_election_node.sv =====
// An accepted beat is captured, the node state is updated in the next cycle, and the
// first result is moved into the output register once the output slot is free.
// The input stays stalled until every result of the item has left; results leave one
// per cycle from the destination mask while the output register is not stalled.
// Reset is synchronous and active low: configuration returns to its defaults, the node
// becomes a follower at term zero, and the LFSR is loaded with the default seed.
`timescale 1ns / 1ps

module raft_leader_election_node
    import rle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Configuration writes are taken in any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer for capture, update and result beats.
    rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    // Election state, timeout randomizer and result generation.
    rle_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule

// ===== hdl/rle_ctrl.sv =====
`timescale 1ns / 1ps

module rle_ctrl
    import rle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_SEND;
            end
            ST_SEND: begin
                if (!i_sts.pending) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // An update cycle only ever follows an accepted beat.
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $past(i_in_valid && r_state == ST_IDLE))
        else $error("update cycle without an accepted beat");

    // A result is only moved when one is pending and the output slot is free.
    a_pop_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> (i_sts.pending && i_sts.out_free))
        else $error("result moved without a pending destination or free slot");

    // The controller is always in exactly one state.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");

endmodule

// ===== hdl/rle_dpath.sv =====
`timescale 1ns / 1ps

module rle_dpath
    import rle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_in_item                i_in_data,
    input  logic                    i_cfg_valid,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_data,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output t_out_item               o_out_data,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts
);

    // Configuration registers.
    logic [C_ID_W-1:0]     r_own_id;
    logic [C_SIZE_W-1:0]   r_cluster_size;
    logic [C_PERIOD_W-1:0] r_hb_period;
    logic [C_PERIOD_W-1:0] r_rv_period;
    logic [C_PERIOD_W-1:0] r_elect_base;

    // Captured input item.
    logic [2:0]            r_op;
    logic [C_ID_W-1:0]     r_sender;
    logic [C_TERM_W-1:0]   r_msg_term;

    // Election state.
    logic [1:0]            r_role,        n_role;
    logic [C_TERM_W-1:0]   r_term,        n_term;
    logic                  r_voted_valid, n_voted_valid;
    logic [C_ID_W-1:0]     r_voted_node,  n_voted_node;
    logic [C_NODES-1:0]    r_bitmap,      n_bitmap;
    logic [C_SIZE_W-1:0]   r_vote_cnt,    n_vote_cnt;
    logic [C_WAIT_W-1:0]   r_wait,        n_wait;
    logic [C_REMAIN_W-1:0] r_remain,      n_remain;
    logic [C_LIMIT_W-1:0]  r_limit,       n_limit;
    logic                  r_woken,       n_woken;
    logic [C_LFSR_W-1:0]   r_lfsr,        n_lfsr;

    // Pending destinations of the current run and their message kind.
    logic [C_NODES-1:0]    r_mask,        n_mask;
    logic [1:0]            r_kind,        n_kind;

    // Output register.
    logic                  r_out_valid;
    t_out_item             r_out_data;

    // Shared helper values.
    logic [C_PERIOD_W-1:0]            base_nz, rv_nz, hb_nz;
    logic [C_LFSR_W-1:0]              lfsr_step;
    logic [C_LFSR_W+C_PERIOD_W-1:0]   scale_prod;
    logic [C_LIMIT_W-1:0]             new_limit;
    logic [C_WAIT_W-1:0]              wait_inc;
    logic                             term_gt, term_eq;
    logic [C_NODES-1:0]               mask_rest;
    logic [C_ID_W-1:0]                low_dest;

    function automatic logic majority(input logic [C_SIZE_W-1:0] cnt,
                                      input logic [C_SIZE_W-1:0] size);
        return {cnt, 1'b0} > {1'b0, size};
    endfunction

    function automatic logic [C_PERIOD_W-1:0] non_zero(input logic [C_PERIOD_W-1:0] v);
        return (v == '0) ? C_PERIOD_W'(1) : v;
    endfunction

    assign base_nz = non_zero(r_elect_base);
    assign rv_nz   = non_zero(r_rv_period);
    assign hb_nz   = non_zero(r_hb_period);

    // One Galois LFSR step and the randomized timeout scaled from it.
    assign lfsr_step  = (r_lfsr >> 1) ^ (r_lfsr[0] ? C_LFSR_TAPS : '0);
    assign scale_prod = lfsr_step * base_nz;
    assign new_limit  = {1'b0, base_nz} + {1'b0, scale_prod[C_LFSR_W +: C_PERIOD_W]};

    assign wait_inc = (r_wait == '1) ? r_wait : r_wait + C_WAIT_W'(1);
    assign term_gt  = (r_msg_term > r_term);
    assign term_eq  = (r_msg_term == r_term);

    // State update for one item.
    always_comb begin
        logic                  do_adopt;
        logic                  do_eval;
        logic                  do_start;
        logic                  do_lead;
        logic                  do_bcast;
        logic [1:0]            bkind;
        logic [C_SIZE_W-1:0]   cnt_new;
        logic [C_WAIT_W-1:0]   round_len;
        logic [C_REMAIN_W-1:0] rem_next;

        n_role        = r_role;
        n_term        = r_term;
        n_voted_valid = r_voted_valid;
        n_voted_node  = r_voted_node;
        n_bitmap      = r_bitmap;
        n_vote_cnt    = r_vote_cnt;
        n_wait        = r_wait;
        n_remain      = r_remain;
        n_limit       = r_limit;
        n_woken       = r_woken;
        n_lfsr        = r_lfsr;
        n_mask        = '0;
        n_kind        = r_kind;
        do_eval       = 1'b0;
        do_start      = 1'b0;
        do_lead       = 1'b0;
        do_bcast      = 1'b0;
        bkind         = KIND_HB;
        cnt_new       = r_vote_cnt + C_SIZE_W'(!r_bitmap[r_sender]);
        round_len     = '0;
        rem_next      = r_remain - {2'b00, rv_nz};

        do_adopt = ((r_op == OP_HEARTBEAT) && (term_gt || term_eq)) ||
                   (((r_op == OP_VOTE_REQ) || (r_op == OP_VOTE)) && term_gt);

        // A newer term or equal-term heartbeat: follower with no vote cast.
        if (do_adopt) begin
            n_term        = r_msg_term;
            n_voted_valid = 1'b0;
            n_voted_node  = '0;
            n_bitmap      = '0;
            n_vote_cnt    = '0;
            n_role        = ROLE_FOLLOWER;
            n_wait        = '0;
            n_woken       = 1'b0;
            n_remain      = '0;
        end

        unique case (r_op)
            OP_HEARTBEAT: begin
                if (do_adopt) begin
                    n_mask = C_NODES'(1) << r_sender;
                    n_kind = KIND_ACK;
                end
            end
            OP_VOTE_REQ: begin
                if (term_gt || (term_eq && (!r_voted_valid || r_voted_node == r_sender))) begin
                    n_voted_valid = 1'b1;
                    n_voted_node  = r_sender;
                    n_role        = ROLE_FOLLOWER;
                    n_wait        = '0;
                    n_woken       = 1'b0;
                    n_remain      = '0;
                    n_mask        = C_NODES'(1) << r_sender;
                    n_kind        = KIND_VOTE;
                end
            end
            OP_VOTE: begin
                if (!term_gt && term_eq && r_role == ROLE_CANDIDATE) begin
                    n_bitmap   = r_bitmap | (C_NODES'(1) << r_sender);
                    n_vote_cnt = cnt_new;
                    if (majority(cnt_new, r_cluster_size)) begin
                        n_woken = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                n_wait = wait_inc;
                if (r_role == ROLE_FOLLOWER) begin
                    if (wait_inc >= r_limit) begin
                        do_start = 1'b1;
                    end
                end else if (r_role == ROLE_CANDIDATE) begin
                    if (r_woken || r_remain[C_REMAIN_W-1] || r_remain == '0) begin
                        do_eval = 1'b1;
                    end else begin
                        round_len = ({2'b00, rv_nz} > r_remain) ?
                                    r_remain[C_WAIT_W-1:0] : {1'b0, rv_nz};
                        if (wait_inc >= round_len) begin
                            if (rem_next[C_REMAIN_W-1] || rem_next == '0) begin
                                do_eval = 1'b1;
                            end else begin
                                n_remain = rem_next;
                                n_wait   = '0;
                                do_bcast = 1'b1;
                                bkind    = KIND_REQ;
                            end
                        end
                    end
                end else begin
                    if (wait_inc >= {1'b0, hb_nz}) begin
                        n_wait   = '0;
                        do_bcast = 1'b1;
                        bkind    = KIND_HB;
                    end
                end
            end
            default: begin
            end
        endcase

        // Election outcome: leader on a majority, otherwise a fresh election.
        if (do_eval) begin
            if (majority(r_vote_cnt, r_cluster_size)) begin
                do_lead = 1'b1;
            end else begin
                do_start = 1'b1;
            end
        end

        // Start an election with a new randomized timeout and the next term.
        if (do_start) begin
            n_lfsr        = lfsr_step;
            n_limit       = new_limit;
            n_remain      = {1'b0, new_limit};
            n_term        = (r_term == '1) ? r_term : r_term + C_TERM_W'(1);
            n_bitmap      = C_NODES'(1) << r_own_id;
            n_vote_cnt    = C_SIZE_W'(1);
            n_role        = ROLE_CANDIDATE;
            n_voted_valid = 1'b1;
            n_voted_node  = r_own_id;
            n_woken       = 1'b0;
            n_wait        = '0;
            if (r_cluster_size <= C_SIZE_W'(1)) begin
                do_lead = 1'b1;
            end else begin
                do_bcast = 1'b1;
                bkind    = KIND_REQ;
            end
        end

        if (do_lead) begin
            n_role   = ROLE_LEADER;
            n_wait   = '0;
            n_woken  = 1'b0;
            do_bcast = 1'b1;
            bkind    = KIND_HB;
        end

        // Broadcast destinations: all cluster members but this node, and for
        // vote requests only those that have not voted yet.
        if (do_bcast) begin
            n_kind = bkind;
            for (int i = 0; i < C_NODES; i++) begin
                n_mask[i] = (C_SIZE_W'(i) < r_cluster_size) && (C_ID_W'(i) != r_own_id) &&
                            !((bkind == KIND_REQ) && n_bitmap[i]);
            end
        end
    end

    // Lowest pending destination goes out first.
    always_comb begin
        low_dest = '0;
        for (int i = C_NODES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_dest = C_ID_W'(i);
            end
        end
    end

    assign mask_rest = r_mask & (r_mask - C_NODES'(1));

    assign o_sts.pending  = (r_mask != '0);
    assign o_sts.last     = (mask_rest == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Configuration, state and run registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id       <= C_RST_OWN_ID;
            r_cluster_size <= C_RST_CLUSTER;
            r_hb_period    <= C_RST_HB_PER;
            r_rv_period    <= C_RST_RV_PER;
            r_elect_base   <= C_RST_BASE;
            r_role         <= ROLE_FOLLOWER;
            r_term         <= '0;
            r_voted_valid  <= 1'b0;
            r_voted_node   <= '0;
            r_bitmap       <= '0;
            r_vote_cnt     <= '0;
            r_wait         <= '0;
            r_remain       <= '0;
            r_limit        <= {1'b0, C_RST_BASE};
            r_woken        <= 1'b0;
            r_mask         <= '0;
            r_kind         <= KIND_ACK;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OWN_ID:       r_own_id       <= i_cfg_data[C_ID_W-1:0];
                    CFG_CLUSTER_SIZE: r_cluster_size <= i_cfg_data[C_SIZE_W-1:0];
                    CFG_HB_PERIOD:    r_hb_period    <= i_cfg_data[C_PERIOD_W-1:0];
                    CFG_RV_PERIOD:    r_rv_period    <= i_cfg_data[C_PERIOD_W-1:0];
                    CFG_ELECT_BASE:   r_elect_base   <= i_cfg_data[C_PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.execute) begin
                r_role        <= n_role;
                r_term        <= n_term;
                r_voted_valid <= n_voted_valid;
                r_voted_node  <= n_voted_node;
                r_bitmap      <= n_bitmap;
                r_vote_cnt    <= n_vote_cnt;
                r_wait        <= n_wait;
                r_remain      <= n_remain;
                r_limit       <= n_limit;
                r_woken       <= n_woken;
                r_mask        <= n_mask;
                r_kind        <= n_kind;
            end else if (i_cmd.pop) begin
                r_mask <= mask_rest;
            end
        end
    end

    // Timeout LFSR: a seed write reloads it, an election steps it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= C_RST_SEED;
        end else if (i_cfg_valid && (i_cfg_index == CFG_RANDOM_SEED)) begin
            r_lfsr <= (i_cfg_data[C_LFSR_W-1:0] == '0) ?
                      C_LFSR_W'(1) : i_cfg_data[C_LFSR_W-1:0];
        end else if (i_cmd.execute) begin
            r_lfsr <= n_lfsr;
        end
    end

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_in_data.operation;
            r_sender   <= i_in_data.sender_id;
            r_msg_term <= i_in_data.msg_term;
        end
    end

    // Output register: one result beat per pop, held while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out_data.send_kind   <= r_kind;
            r_out_data.dest_id     <= low_dest;
            r_out_data.send_term   <= r_term;
            r_out_data.node_role   <= r_role;
            r_out_data.last_of_run <= (mask_rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The vote count tracks the bitmap of votes received.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vote_cnt == C_SIZE_W'($countones(r_bitmap)))
        else $error("vote count out of step with voter bitmap");

    // The timeout LFSR never locks up at zero.
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("timeout LFSR reached zero");

    // The final result of a run leaves nothing pending.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop && o_sts.last) |=> !o_sts.pending)
        else $error("destinations left after the final result");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rle_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_GAP        = 5;
    localparam int MAX_REPORTS    = 10;
    localparam int RUN_LIMIT_NS   = 5_000_000;
    localparam int WAIT_SAT       = 511;
    localparam int ELECT_TICK_CAP = 600;
    localparam int HOLD_CYCLES    = 150;

    // Operation codes that the node leaves undefined and must ignore.
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    t_in_item                in_data   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [C_CFG_IDX_W-1:0]  cfg_index = '0;
    logic [C_CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the configuration registers.
    logic [C_ID_W-1:0]     cfg_own;
    logic [C_SIZE_W-1:0]   cfg_size;
    logic [C_PERIOD_W-1:0] cfg_hb;
    logic [C_PERIOD_W-1:0] cfg_rv;
    logic [C_PERIOD_W-1:0] cfg_base;

    // Predicted election state of the node.
    logic [1:0]          node_role;
    logic [C_TERM_W-1:0] node_term;
    logic                has_voted;
    logic [C_ID_W-1:0]   voted_for;
    logic [C_NODES-1:0]  vote_tally;
    int                  idle_ticks;
    int                  elect_left;
    int                  elect_limit;
    logic                tally_won;
    logic [C_LFSR_W-1:0] lfsr;

    // Messages of the current step, and all messages still owed by the node.
    t_out_item step_msgs[$];
    t_out_item outbound_q[$];

    int fail_count = 0;
    int rx_hold    = 0;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;

    raft_leader_election_node u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // Node model: state after reset.
    function automatic void reset_node_model();
        cfg_own     = C_RST_OWN_ID;
        cfg_size    = C_RST_CLUSTER;
        cfg_hb      = C_RST_HB_PER;
        cfg_rv      = C_RST_RV_PER;
        cfg_base    = C_RST_BASE;
        node_role   = ROLE_FOLLOWER;
        node_term   = '0;
        has_voted   = 1'b0;
        voted_for   = '0;
        vote_tally  = '0;
        idle_ticks  = 0;
        elect_left  = 0;
        elect_limit = int'(C_RST_BASE);
        tally_won   = 1'b0;
        lfsr        = C_RST_SEED;
    endfunction

    // A zero period, base or seed behaves as one.
    function automatic int at_least_one(input logic [C_PERIOD_W-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic bit has_majority();
        return 2 * $countones(vote_tally) > int'(cfg_size);
    endfunction

    function automatic void shadow_reg(input logic [C_CFG_IDX_W-1:0] idx,
                                       input logic [C_CFG_DATA_W-1:0] val);
        case (idx)
            CFG_OWN_ID:       cfg_own  = val[C_ID_W-1:0];
            CFG_CLUSTER_SIZE: cfg_size = val[C_SIZE_W-1:0];
            CFG_HB_PERIOD:    cfg_hb   = val[C_PERIOD_W-1:0];
            CFG_RV_PERIOD:    cfg_rv   = val[C_PERIOD_W-1:0];
            CFG_ELECT_BASE:   cfg_base = val[C_PERIOD_W-1:0];
            CFG_RANDOM_SEED:  lfsr     = (val == '0) ? C_LFSR_W'(1) : val;
            default: ;
        endcase
    endfunction

    // One outgoing message; role and last flag are filled in at the end of the step.
    function automatic void emit_msg(input logic [1:0] kind, input logic [C_ID_W-1:0] dest);
        t_out_item m;
        if (step_msgs.size() >= C_NODES) return;
        m           = '0;
        m.send_kind = kind;
        m.dest_id   = dest;
        m.send_term = node_term;
        step_msgs.push_back(m);
    endfunction

    // Send to every peer below the cluster size; requests skip nodes that already voted.
    function automatic void broadcast(input logic [1:0] kind);
        int n;
        n = (int'(cfg_size) > C_NODES) ? C_NODES : int'(cfg_size);
        for (int i = 0; i < n; i++) begin
            if (i == int'(cfg_own)) continue;
            if (kind == KIND_REQ && vote_tally[i]) continue;
            emit_msg(kind, C_ID_W'(i));
        end
    endfunction

    function automatic void become_follower();
        node_role  = ROLE_FOLLOWER;
        idle_ticks = 0;
        tally_won  = 1'b0;
        elect_left = 0;
    endfunction

    function automatic void adopt_term(input logic [C_TERM_W-1:0] t);
        node_term  = t;
        has_voted  = 1'b0;
        voted_for  = '0;
        vote_tally = '0;
        become_follower();
    endfunction

    function automatic void become_leader();
        node_role  = ROLE_LEADER;
        idle_ticks = 0;
        tally_won  = 1'b0;
        broadcast(KIND_HB);
    endfunction

    // New election: step the LFSR, draw the timeout, vote for ourselves.
    function automatic void start_election();
        int   base_ticks;
        logic lsb;
        base_ticks = at_least_one(cfg_base);
        lsb        = lfsr[0];
        lfsr       = lfsr >> 1;
        if (lsb) begin
            lfsr = lfsr ^ C_LFSR_TAPS;
        end
        elect_limit = base_ticks + ((int'(lfsr) * base_ticks) >> 16);
        elect_left  = elect_limit;
        if (node_term != '1) begin
            node_term = node_term + 1'b1;
        end
        vote_tally          = '0;
        vote_tally[cfg_own] = 1'b1;
        node_role           = ROLE_CANDIDATE;
        has_voted           = 1'b1;
        voted_for           = cfg_own;
        tally_won           = 1'b0;
        idle_ticks          = 0;
        if (cfg_size <= 1) begin
            become_leader();
        end else begin
            broadcast(KIND_REQ);
        end
    endfunction

    function automatic void evaluate_election();
        if (has_majority()) begin
            become_leader();
        end else begin
            has_voted  = 1'b0;
            voted_for  = '0;
            vote_tally = '0;
            start_election();
        end
    endfunction

    function automatic void tick_node();
        int rvp;
        int round_ticks;
        if (idle_ticks < WAIT_SAT) begin
            idle_ticks++;
        end
        if (node_role == ROLE_FOLLOWER) begin
            if (idle_ticks >= elect_limit) start_election();
        end else if (node_role == ROLE_CANDIDATE) begin
            rvp         = at_least_one(cfg_rv);
            round_ticks = rvp;
            if (tally_won || elect_left <= 0) begin
                evaluate_election();
            end else begin
                if (round_ticks > elect_left) round_ticks = elect_left;
                if (idle_ticks >= round_ticks) begin
                    elect_left -= rvp;
                    if (elect_left <= 0) begin
                        evaluate_election();
                    end else begin
                        idle_ticks = 0;
                        broadcast(KIND_REQ);
                    end
                end
            end
        end else begin
            if (idle_ticks >= at_least_one(cfg_hb)) begin
                idle_ticks = 0;
                broadcast(KIND_HB);
            end
        end
    endfunction

    // Apply one accepted input beat to the model and queue the messages it causes.
    function automatic void step_node(input t_in_item item);
        logic [C_ID_W-1:0]   snd;
        logic [C_TERM_W-1:0] mt;
        t_out_item           m;
        snd = item.sender_id;
        mt  = item.msg_term;
        step_msgs.delete();
        case (item.operation)
            OP_HEARTBEAT: begin
                if (mt >= node_term) begin
                    adopt_term(mt);
                    emit_msg(KIND_ACK, snd);
                end
            end
            OP_VOTE_REQ: begin
                if (mt > node_term) adopt_term(mt);
                if (mt == node_term && (!has_voted || voted_for == snd)) begin
                    has_voted = 1'b1;
                    voted_for = snd;
                    become_follower();
                    emit_msg(KIND_VOTE, snd);
                end
            end
            OP_VOTE: begin
                if (mt > node_term) adopt_term(mt);
                if (mt == node_term && node_role == ROLE_CANDIDATE) begin
                    vote_tally[snd] = 1'b1;
                    if (has_majority()) tally_won = 1'b1;
                end
            end
            OP_TICK: begin
                tick_node();
            end
            default: ;
        endcase
        foreach (step_msgs[i]) begin
            m             = step_msgs[i];
            m.node_role   = node_role;
            m.last_of_run = (i == step_msgs.size() - 1);
            outbound_q.push_back(m);
        end
    endfunction

    // Compare one received message with the oldest one the model owes.
    function automatic void check_msg(input t_out_item got);
        t_out_item want;
        if (outbound_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("ERROR %0t: unexpected result kind=%0d dest=%0d term=%0h role=%0d last=%0d",
                         $time, got.send_kind, got.dest_id, got.send_term, got.node_role,
                         got.last_of_run);
            end
            return;
        end
        want = outbound_q.pop_front();
        if (got.send_kind !== want.send_kind || got.dest_id !== want.dest_id ||
            got.send_term !== want.send_term || got.node_role !== want.node_role ||
            got.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("ERROR %0t: expected kind=%0d dest=%0d term=%0h role=%0d last=%0d",
                         $time, want.send_kind, want.dest_id, want.send_term,
                         want.node_role, want.last_of_run);
                $display("      %0t: actual   kind=%0d dest=%0d term=%0h role=%0d last=%0d",
                         $time, got.send_kind, got.dest_id, got.send_term,
                         got.node_role, got.last_of_run);
            end
        end
    endfunction

    function automatic t_in_item build(input logic [2:0] op, input logic [C_ID_W-1:0] snd,
                                       input logic [C_TERM_W-1:0] term_val);
        t_in_item it;
        it.operation = op;
        it.sender_id = snd;
        it.msg_term  = term_val;
        return it;
    endfunction

    // Mostly cluster members, now and then any index.
    function automatic logic [C_ID_W-1:0] pick_sender();
        int hi;
        hi = ((int'(cfg_size) > C_NODES) ? C_NODES : int'(cfg_size)) - 1;
        if (hi < 0) hi = 0;
        if ($urandom_range(0, 4) == 0) return C_ID_W'($urandom_range(0, C_NODES - 1));
        return C_ID_W'($urandom_range(0, hi));
    endfunction

    // Terms cluster around the current one so that messages are not simply stale.
    function automatic logic [C_TERM_W-1:0] pick_term();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return node_term;
        if (r < 68) return node_term + 1'b1;
        if (r < 82) return node_term - 1'b1;
        return C_TERM_W'($urandom);
    endfunction

    function automatic t_in_item random_item(input int tick_pct);
        t_in_item it;
        int       r;
        it = build(OP_TICK, pick_sender(), pick_term());
        if ($urandom_range(0, 99) < tick_pct) return it;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            it.operation = OP_VOTE;
        end else if (r < 55) begin
            it.operation = OP_HEARTBEAT;
        end else if (r < 75) begin
            it.operation = OP_VOTE_REQ;
        end else if (r < 84) begin
            it.operation = OP_ACK;
        end else if (r < 92) begin
            it.operation = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        end else begin
            it = {3'($urandom), C_ID_W'($urandom), C_TERM_W'($urandom)};
        end
        return it;
    endfunction

    function automatic bit is_ignored(input t_in_item it);
        return it.operation == OP_ACK || it.operation > OP_TICK;
    endfunction

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall !== 1'b0);
        step_node(item);
    endtask

    // Stop offering beats, let every owed message arrive, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outbound_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        shadow_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [C_CFG_DATA_W-1:0] own, n_nodes, hb, rv, base_ticks,
                             seed_val);
        write_reg(CFG_OWN_ID, own);
        write_reg(CFG_CLUSTER_SIZE, n_nodes);
        write_reg(CFG_HB_PERIOD, hb);
        write_reg(CFG_RV_PERIOD, rv);
        write_reg(CFG_ELECT_BASE, base_ticks);
        write_reg(CFG_RANDOM_SEED, seed_val);
    endtask

    // Feed ticks until the follower times out and runs for election.
    task automatic tick_until_election();
        int n;
        n = 0;
        while (node_role == ROLE_FOLLOWER && n < ELECT_TICK_CAP) begin
            send_item(build(OP_TICK, '0, '0));
            n++;
        end
    endtask

    // One configuration, then random traffic with a pause for a full drain halfway.
    task automatic run_phase(input logic [C_CFG_DATA_W-1:0] own, n_nodes, hb, rv, base_ticks,
                             seed_val, input int count, input int tick_pct);
        t_in_item it;
        int       done;
        bit       paused;
        wait_idle();
        configure(own, n_nodes, hb, rv, base_ticks, seed_val);
        // A heartbeat one term up puts the node back to a fresh follower.
        send_item(build(OP_HEARTBEAT, pick_sender(), node_term + 1'b1));
        done   = 0;
        paused = 1'b0;
        while (done < count) begin
            if (done % 25 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (!paused && done >= count / 2) begin
                paused = 1'b1;
                wait_idle();
            end
            it = random_item(tick_pct);
            send_item(it);
            if (!is_ignored(it)) done++;
        end
    endtask

    // Reset defaults: ignored inputs, replies, vote rules, a full election.
    task automatic test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(build(OP_ACK, 4'd1, '0));
        for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++) begin
            send_item(build(3'(op), 4'd2, 32'd9));
        end
        send_item(build(OP_HEARTBEAT, 4'd2, '0));
        send_item(build(OP_VOTE_REQ, 4'd1, '0));
        // A second candidate in the same term is refused, the first one granted again.
        send_item(build(OP_VOTE_REQ, 4'd2, '0));
        send_item(build(OP_VOTE_REQ, 4'd1, '0));
        send_item(build(OP_VOTE, 4'd1, '0));
        send_item(build(OP_HEARTBEAT, 4'd15, 32'd7));
        send_item(build(OP_HEARTBEAT, 4'd3, 32'd2));
        tick_until_election();
        send_item(build(OP_VOTE, 4'd1, node_term));
        send_item(build(OP_TICK, '0, '0));
        send_item(build(OP_VOTE_REQ, 4'd2, 32'd3));
        // A vote from a later term makes the leader step down.
        send_item(build(OP_VOTE, 4'd2, node_term + 1'b1));
        wait_idle();
    endtask

    // The receiver holds off long enough for the node to fill up and stall its input.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_hold    = HOLD_CYCLES;
        repeat (40) send_item(build(OP_HEARTBEAT, pick_sender(), node_term));
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_phases();
        // Large cluster with the shortest periods.
        run_phase(16'd5, 16'd16, 16'd1, 16'd1, 16'd1, 16'd1, 40, 55);
        // Single node, all periods and the seed at zero; this node sits outside the cluster.
        run_phase(16'd15, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 25, 60);
        // Single node with no peers at all.
        run_phase(16'd0, 16'd1, 16'd3, 16'd2, 16'd2, 16'd77, 15, 60);
        run_phase(16'd3, 16'd2, 16'd3, 16'd2, 16'd4, 16'hFFFF, 40, 55);
        run_phase(16'd12, 16'd5, 16'd7, 16'd3, 16'd6, 16'($urandom_range(1, 65535)), 40, 55);
        repeat (2) begin
            run_phase(16'($urandom_range(0, C_NODES - 1)), 16'($urandom_range(1, C_NODES)),
                      16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                      16'($urandom_range(1, 20)), 16'($urandom_range(1, 65535)), 30, 55);
        end
        // Longest periods and timeout, mostly ticks.
        run_phase(16'd0, 16'd2, 16'd255, 16'd255, 16'd255, 16'd2, 120, 96);
    endtask

    // At the largest term a new election keeps the term where it is.
    task automatic test_term_saturation();
        wait_idle();
        configure(16'd1, 16'd3, 16'd2, 16'd2, 16'd1, 16'd1);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_item(build(OP_HEARTBEAT, 4'd2, '1));
        tick_until_election();
        send_item(build(OP_VOTE, 4'd0, '1));
        send_item(build(OP_TICK, '0, '0));
        send_item(build(OP_VOTE_REQ, 4'd2, '1));
        send_item(build(OP_HEARTBEAT, 4'd0, '1));
        wait_idle();
    endtask

    // Receive side: check each result beat and draw the stall before the next one.
    initial begin : rx_side
        int stall_left;
        bit took;
        stall_left = 0;
        forever begin
            @(posedge clk);
            took = rst_n && out_valid && !out_stall;
            if (took) begin
                check_msg(out_data);
                stall_left = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Main sequence.
    initial begin
        reset_node_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        test_term_saturation();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
